@@ hw/rtl/csds_pkg.sv @@
// ============================================================================
// csds_pkg: shared definitions for the C-SCAN seek scheduler
// Sizes, register map, and the command and status words that run between
// the controller and the datapath.
// ============================================================================
package csds_pkg;

  // Storage sizing. The store holds up to MAX_REQUESTS requests of a batch plus the head.
  localparam int MAX_REQUESTS = 16;
  localparam int STORE_DEPTH  = MAX_REQUESTS + 1;
  localparam int IDX_W        = $clog2(STORE_DEPTH);
  localparam int CNT_W        = $clog2(STORE_DEPTH + 1);

  // Field widths.
  localparam int CYL_W  = 16;
  localparam int DISK_W = 17;
  localparam int SUM_W  = 18;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_DISK_CYL   = 1'b0;
  localparam logic REG_HEAD_START = 1'b1;
  localparam logic [DISK_W-1:0] DISK_CYL_RESET = 17'd200;

  // Source of the cylinder placed in the output word.
  typedef enum logic [1:0] {
    SEL_ENTRY,
    SEL_TOP,
    SEL_ZERO
  } emit_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      ins_req;      // insert the input request into the sorted store
    logic      ins_head;     // insert the head position into the sorted store
    logic      clr_idx;      // walk index back to zero
    logic      inc_idx;      // advance the walk index
    logic      latch_below;  // capture the walk index as the head position
    logic      start_burst;  // restart seek tracking at the head
    logic      emit;         // load the output word
    emit_sel_t sel;          // cylinder source for the output word
    logic      last;         // final visit of the burst
    logic      clr_count;    // batch finished
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;            // no room left for requests
    logic idx_lt_n;        // walk index is on a stored entry
    logic entry_lt_head;   // entry at the walk index lies below the head
    logic idx_last_n;      // walk index is on the top stored entry
    logic idx_last_below;  // walk index is on the last entry below the head
    logic below_zero;      // no entry lies below the head
    logic out_free;        // output word can be loaded this cycle
  } dp_status_t;

endpackage

@@ hw/rtl/cscan_disk_seek_scheduler_unit.sv @@
// ============================================================================
// cscan_disk_seek_scheduler_unit: C-SCAN disk seek scheduler
// Collects a batch of cylinder requests and emits their C-SCAN visit order
// with the running seek distance.
// ============================================================================
// Requests are taken one word per cycle while loading, and kept in a sorted
// store of up to MAX_REQUESTS entries; further requests in the same batch are
// dropped, but a dropped final request still closes the batch. After the final
// request the block inserts the head position and then walks the sorted store
// one entry per cycle to find where the head sits. It then emits n+2 result
// words (n = stored requests + 1), one per cycle while the output side takes
// them: the upward sweep from the head, the top cylinder, cylinder 0 (the
// return counts as a full seek), then the entries below the head. No request
// is accepted from the final request until the last visit is loaded into
// the output register. Disk size and head start are written through the
// APB port at byte addresses 0 and 4; they must be written only while the
// block is idle, and the block itself does not enforce this.
module cscan_disk_seek_scheduler_unit
  import csds_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CYL_W-1:0]   in_request_cylinder,
  input  logic               in_final_request,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CYL_W-1:0]   out_visit_cylinder,
  output logic [SUM_W-1:0]   out_seek_total,
  output logic               out_last_visit,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  ctrl_cmd_t         cmd;
  dp_status_t        sts;
  logic [DISK_W-1:0] disk_cylinders;
  logic [CYL_W-1:0]  head_start;

  // Configuration registers.
  csds_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .disk_cylinders (disk_cylinders),
    .head_start     (head_start)
  );

  // Sequencer.
  csds_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_final_request (in_final_request),
    .in_ready         (in_ready),
    .sts              (sts),
    .cmd              (cmd)
  );

  // Store, accumulator and output word.
  csds_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_request_cylinder (in_request_cylinder),
    .disk_cylinders      (disk_cylinders),
    .head_start          (head_start),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_visit_cylinder  (out_visit_cylinder),
    .out_seek_total      (out_seek_total),
    .out_last_visit      (out_last_visit)
  );

endmodule

@@ hw/rtl/csds_cfg.sv @@
// ============================================================================
// csds_cfg: configuration registers
// APB-style register file holding the disk size and the starting head.
// ============================================================================
module csds_cfg
  import csds_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  output logic [DISK_W-1:0]   disk_cylinders,
  output logic [CYL_W-1:0]    head_start
);

  logic [DISK_W-1:0] disk_cyl_r;
  logic [CYL_W-1:0]  head_start_r;
  logic              wr_en;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  // Registers sit on word boundaries; bit 2 picks the word.
  assign reg_sel = paddr[2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_cyl_r   <= DISK_CYL_RESET;
      head_start_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DISK_CYL:   disk_cyl_r   <= pwdata[DISK_W-1:0];
        REG_HEAD_START: head_start_r <= pwdata[CYL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_sel)
      REG_DISK_CYL:   prdata = PDATA_W'(disk_cyl_r);
      REG_HEAD_START: prdata = PDATA_W'(head_start_r);
      default:        prdata = '0;
    endcase
  end

  assign disk_cylinders = disk_cyl_r;
  assign head_start     = head_start_r;

endmodule

@@ hw/rtl/csds_ctrl.sv @@
// ============================================================================
// csds_ctrl: scheduler controller
// Sequences loading, head insertion, the head search and the visit burst.
// ============================================================================
module csds_ctrl
  import csds_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_final_request,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_HEAD,
    S_SCAN,
    S_UP,
    S_TOP,
    S_ZERO,
    S_LOW
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_acc;

  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_ENTRY;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cmd.ins_req = !sts.full;
          if (in_final_request) begin
            state_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        cmd.ins_head = 1'b1;
        cmd.clr_idx  = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        // Step over every entry below the head.
        if (sts.idx_lt_n && sts.entry_lt_head) begin
          cmd.inc_idx = 1'b1;
        end else begin
          cmd.latch_below = 1'b1;
          cmd.start_burst = 1'b1;
          state_nxt       = S_UP;
        end
      end
      S_UP: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.inc_idx = 1'b1;
          if (sts.idx_last_n) begin
            state_nxt = S_TOP;
          end
        end
      end
      S_TOP: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_TOP;
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_ZERO;
          cmd.last    = sts.below_zero;
          cmd.clr_idx = 1'b1;
          if (sts.below_zero) begin
            cmd.clr_count = 1'b1;
            state_nxt     = S_LOAD;
          end else begin
            state_nxt = S_LOW;
          end
        end
      end
      S_LOW: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.last    = sts.idx_last_below;
          cmd.inc_idx = 1'b1;
          if (sts.idx_last_below) begin
            cmd.clr_count = 1'b1;
            state_nxt     = S_LOAD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/csds_dpath.sv @@
// ============================================================================
// csds_dpath: scheduler datapath
// Sorted request store, walk index, seek accumulator and output word.
// ============================================================================
module csds_dpath
  import csds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        sts,
  input  logic [CYL_W-1:0]  in_request_cylinder,
  input  logic [DISK_W-1:0] disk_cylinders,
  input  logic [CYL_W-1:0]  head_start,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CYL_W-1:0]  out_visit_cylinder,
  output logic [SUM_W-1:0]  out_seek_total,
  output logic              out_last_visit
);

  logic [CYL_W-1:0]  store_r   [STORE_DEPTH];
  logic [CYL_W-1:0]  store_nxt [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] ins_pos;
  logic [CYL_W-1:0]  ins_val;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  below_r;
  logic [CYL_W-1:0]  cur_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic              out_valid_r;
  logic [CYL_W-1:0]  out_cyl_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic              out_last_r;
  logic [CYL_W-1:0]  rd_val;
  logic [CYL_W-1:0]  top_cyl;
  logic [DISK_W-1:0] disk_m1;
  logic [CYL_W-1:0]  emit_cyl;
  logic [CYL_W-1:0]  gap;

  // Insertion into the sorted store: entries above the new value move up.
  assign ins_val = cmd.ins_head ? head_start : in_request_cylinder;

  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      ins_pos[k] = ((CNT_W'(k) < count_r) && (store_r[k] > ins_val)) ||
                   (CNT_W'(k) == count_r);
    end
    for (int k = 0; k < STORE_DEPTH; k++) begin
      if (k > 0 && ins_pos[(k > 0) ? k - 1 : 0]) begin
        store_nxt[k] = store_r[(k > 0) ? k - 1 : 0];
      end else if (ins_pos[k]) begin
        store_nxt[k] = ins_val;
      end else begin
        store_nxt[k] = store_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_req || cmd.ins_head) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
        store_r[k] <= store_nxt[k];
      end
    end
  end

  // Entry under the walk index.
  assign rd_val = store_r[idx_r[IDX_W-1:0]];

  // Top cylinder: a zero disk size counts as one, a large one saturates.
  assign disk_m1 = disk_cylinders - DISK_W'(1);
  always_comb begin
    if (disk_cylinders == '0) begin
      top_cyl = '0;
    end else if (disk_m1[DISK_W-1]) begin
      top_cyl = '1;
    end else begin
      top_cyl = disk_m1[CYL_W-1:0];
    end
  end

  // Cylinder of the next visit and the seek it costs.
  always_comb begin
    unique case (cmd.sel)
      SEL_ENTRY: emit_cyl = rd_val;
      SEL_TOP:   emit_cyl = top_cyl;
      SEL_ZERO:  emit_cyl = '0;
      default:   emit_cyl = '0;
    endcase
  end

  assign gap     = (emit_cyl >= cur_r) ? (emit_cyl - cur_r) : (cur_r - emit_cyl);
  assign sum_nxt = sum_r + SUM_W'(gap);

  // Control counters and seek tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      below_r     <= '0;
      cur_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_count) begin
        count_r <= '0;
      end else if (cmd.ins_req || cmd.ins_head) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.clr_idx) begin
        idx_r <= '0;
      end else if (cmd.inc_idx) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.latch_below) begin
        below_r <= idx_r;
      end
      if (cmd.start_burst) begin
        cur_r <= head_start;
        sum_r <= '0;
      end else if (cmd.emit) begin
        cur_r <= emit_cyl;
        sum_r <= sum_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cyl_r  <= emit_cyl;
      out_sum_r  <= sum_nxt;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_visit_cylinder = out_cyl_r;
  assign out_seek_total     = out_sum_r;
  assign out_last_visit     = out_last_r;

  // Status to the controller.
  always_comb begin
    sts                = '0;
    sts.full           = (count_r == CNT_W'(MAX_REQUESTS));
    sts.idx_lt_n       = (idx_r < count_r);
    sts.entry_lt_head  = (rd_val < head_start);
    sts.idx_last_n     = ((idx_r + CNT_W'(1)) == count_r);
    sts.idx_last_below = ((idx_r + CNT_W'(1)) == below_r);
    sts.below_zero     = (below_r == '0);
    sts.out_free       = !out_valid_r || out_ready;
  end

  // The store never holds more than MAX_REQUESTS requests plus the head.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STORE_DEPTH))
    else $error("request count beyond store depth");

  // A visited entry always lies inside the filled part of the store.
  a_entry_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.sel == SEL_ENTRY) |-> (idx_r < count_r))
    else $error("visit reads an unfilled store entry");

  // A waiting output word is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("output word overwritten before it was taken");

  // No insertion while a burst is being emitted.
  a_no_insert_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(cmd.ins_req || cmd.ins_head))
    else $error("store changed during a visit burst");

endmodule
